@@ hw/rtl/tts_pkg.sv @@
// Package for the timer table scheduler: op codes, result kinds, sequencer
// states and the packed table entry. Used by the table memory and the top level.
// No dependencies.
package tts_pkg;

    localparam int TIME_W = 32;
    localparam int ID_W   = 32;

    typedef enum logic [2:0] {
        OP_SET        = 3'd0,
        OP_DELETE     = 3'd1,
        OP_TICK       = 3'd2,
        OP_PAUSE      = 3'd3,
        OP_RESUME     = 3'd4,
        OP_ENG_PAUSE  = 3'd5,
        OP_ENG_RESUME = 3'd6
    } t_op;

    localparam logic KIND_FIRED   = 1'b0;
    localparam logic KIND_REFUSED = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_APPEND,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic signed [ID_W-1:0] id;
        logic [TIME_W-1:0]      script;
        logic [TIME_W-1:0]      duration;
        logic                   repeats;
        logic [TIME_W-1:0]      deadline;
    } t_entry;

endpackage

@@ hw/rtl/timer_table_scheduler.sv @@
// Timer table scheduler top level: command channel in, fired/refused results out.
// Depends on tts_pkg and tts_table.
//
// Usage:
//   The slave channel takes one command item: tuser holds the op code, tdata
//   the timer id, script, duration, repeat flag and current time. The master
//   channel returns result items: fired timers during a tick, or a refusal
//   when a set finds the table full. tlast marks the final result of a command.
//   Commands without results (pause, resume, delete, most sets) return nothing.
//
// Table and throughput:
//   Entries live compacted in a table memory with one write port and one
//   registered read port; one shared adder and the id and due comparators
//   handle one entry per cycle, except while a tick holds for a stalled output.
//   Ready is high only while idle; a tick compacts the table in the same pass.
//
// Reset and stall:
//   Synchronous active-low reset empties the table (fill count to zero),
//   clears the pause state and drops any pending result; no clearing pass.
//   A fired result waits one entry in a holding register so that tlast can be
//   set on the final one; when the output register is still full the scan
//   holds on the current entry until the receiver takes the item.
module timer_table_scheduler
    import tts_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // command channel
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata, low to high: timer_id[31:0], script_index[63:32],
    // duration_ms[95:64], repeats[96], now_ms[128:97], zero fill[135:129]
    input  logic [135:0] i_s_axis_tdata,
    // tuser: op[2:0]
    input  logic [2:0]   i_s_axis_tuser,
    // result channel
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata, low to high: fired_script[31:0], fired_id[63:32]
    output logic [63:0]  o_m_axis_tdata,
    // tuser: kind[0]
    output logic [0:0]   o_m_axis_tuser,
    output logic         o_m_axis_tlast
);

    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TIMER_SLOTS);

    // sequencer and command registers
    t_state                 r_state, n_state;
    t_op                    r_op, n_op;
    logic signed [ID_W-1:0] r_id, n_id;
    logic [TIME_W-1:0]      r_script, n_script;
    logic [TIME_W-1:0]      r_dur, n_dur;
    logic                   r_rep, n_rep;
    logic [TIME_W-1:0]      r_now, n_now;

    // table bookkeeping
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_idx, n_idx;
    logic [CW-1:0]          r_wr, n_wr;
    logic                   r_found, n_found;
    logic [TIME_W-1:0]      r_span, n_span;

    // pause state
    logic                   r_paused, n_paused;
    logic                   r_pbg, n_pbg;
    logic [TIME_W-1:0]      r_ptime, n_ptime;

    // holding register for the newest result
    logic                   r_pend_vld, n_pend_vld;
    logic                   r_pend_kind, n_pend_kind;
    logic [TIME_W-1:0]      r_pend_script, n_pend_script;
    logic signed [ID_W-1:0] r_pend_id, n_pend_id;

    // output register
    logic                   r_out_vld, n_out_vld;
    logic                   r_out_kind, n_out_kind;
    logic [TIME_W-1:0]      r_out_script, n_out_script;
    logic signed [ID_W-1:0] r_out_id, n_out_id;
    logic                   r_out_last, n_out_last;

    // table port
    logic                   mem_wr_en;
    logic [AW-1:0]          mem_wr_addr;
    t_entry                 mem_wr_entry;
    logic                   mem_rd_en;
    logic [AW-1:0]          mem_rd_addr;
    t_entry                 mem_rd_entry;

    // shared adder
    logic [TIME_W-1:0]      add_a, add_b, add_sum;
    logic                   add_cin;

    logic                   s_accept;
    logic                   out_free;
    logic                   push;
    logic                   push_last;
    logic [CW-1:0]          idx_inc;
    logic                   more;
    logic                   is_due;
    logic                   id_hit;

    tts_table #(
        .DEPTH (TIMER_SLOTS)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (mem_wr_en),
        .i_wr_addr  (mem_wr_addr),
        .i_wr_entry (mem_wr_entry),
        .i_rd_en    (mem_rd_en),
        .i_rd_addr  (mem_rd_addr),
        .o_rd_entry (mem_rd_entry)
    );

    assign add_sum  = add_a + add_b + TIME_W'(add_cin);
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_vld || i_m_axis_tready;
    assign idx_inc  = r_idx + CW'(1);
    assign more     = (idx_inc != r_count);
    assign is_due   = (r_now >= mem_rd_entry.deadline);
    assign id_hit   = (mem_rd_entry.id == r_id);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_id, r_out_script};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_paused   <= 1'b0;
            r_pbg      <= 1'b0;
            r_ptime    <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_paused   <= n_paused;
            r_pbg      <= n_pbg;
            r_ptime    <= n_ptime;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_id          <= n_id;
        r_script      <= n_script;
        r_dur         <= n_dur;
        r_rep         <= n_rep;
        r_now         <= n_now;
        r_idx         <= n_idx;
        r_wr          <= n_wr;
        r_found       <= n_found;
        r_span        <= n_span;
        r_pend_kind   <= n_pend_kind;
        r_pend_script <= n_pend_script;
        r_pend_id     <= n_pend_id;
        r_out_kind    <= n_out_kind;
        r_out_script  <= n_out_script;
        r_out_id      <= n_out_id;
        r_out_last    <= n_out_last;
    end

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_id          = r_id;
        n_script      = r_script;
        n_dur         = r_dur;
        n_rep         = r_rep;
        n_now         = r_now;
        n_count       = r_count;
        n_idx         = r_idx;
        n_wr          = r_wr;
        n_found       = r_found;
        n_span        = r_span;
        n_paused      = r_paused;
        n_pbg         = r_pbg;
        n_ptime       = r_ptime;
        n_pend_vld    = r_pend_vld;
        n_pend_kind   = r_pend_kind;
        n_pend_script = r_pend_script;
        n_pend_id     = r_pend_id;

        mem_wr_en     = 1'b0;
        mem_wr_addr   = r_wr[AW-1:0];
        mem_wr_entry  = mem_rd_entry;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = '0;

        add_a         = r_now;
        add_b         = r_dur;
        add_cin       = 1'b0;

        push          = 1'b0;
        push_last     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_op     = t_op'(i_s_axis_tuser);
                    n_id     = i_s_axis_tdata[31:0];
                    n_script = i_s_axis_tdata[63:32];
                    n_dur    = i_s_axis_tdata[95:64];
                    n_rep    = i_s_axis_tdata[96];
                    n_now    = i_s_axis_tdata[128:97];
                    n_state  = S_START;
                end
            end

            S_START: begin
                n_idx   = '0;
                n_wr    = '0;
                n_found = 1'b0;
                n_state = S_IDLE;
                case (r_op)
                    OP_SET: begin
                        if (r_count != '0) begin
                            mem_rd_en = 1'b1;
                            n_state   = S_SCAN;
                        end else begin
                            n_state = S_APPEND;
                        end
                    end
                    OP_DELETE: begin
                        if (r_count != '0) begin
                            mem_rd_en = 1'b1;
                            n_state   = S_SCAN;
                        end
                    end
                    OP_TICK: begin
                        if (!r_paused && r_count != '0) begin
                            mem_rd_en = 1'b1;
                            n_state   = S_SCAN;
                        end
                    end
                    OP_PAUSE, OP_ENG_PAUSE: begin
                        if (r_op == OP_ENG_PAUSE) begin
                            n_pbg = r_paused;
                        end
                        if (!r_paused) begin
                            n_paused = 1'b1;
                            n_ptime  = r_now;
                        end
                    end
                    OP_RESUME, OP_ENG_RESUME: begin
                        // span = now - pause_time through the shared adder
                        add_a   = r_now;
                        add_b   = ~r_ptime;
                        add_cin = 1'b1;
                        n_span  = add_sum;
                        if (r_paused && !(r_op == OP_ENG_RESUME && r_pbg)) begin
                            n_paused = 1'b0;
                            if (r_count != '0) begin
                                mem_rd_en = 1'b1;
                                n_state   = S_SCAN;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_SCAN: begin
                case (r_op)
                    OP_SET: begin
                        if (id_hit) begin
                            // update in place and stop the scan
                            mem_wr_en             = 1'b1;
                            mem_wr_addr           = r_idx[AW-1:0];
                            mem_wr_entry.id       = r_id;
                            mem_wr_entry.script   = r_script;
                            mem_wr_entry.duration = r_dur;
                            mem_wr_entry.repeats  = r_rep;
                            mem_wr_entry.deadline = add_sum;
                            n_state               = S_IDLE;
                        end else if (more) begin
                            n_idx       = idx_inc;
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = idx_inc[AW-1:0];
                        end else begin
                            n_state = S_APPEND;
                        end
                    end

                    OP_DELETE: begin
                        if (id_hit && !r_found) begin
                            n_found = 1'b1;
                        end else begin
                            // shift down over the removed slot
                            mem_wr_en = 1'b1;
                            n_wr      = r_wr + CW'(1);
                        end
                        if (more) begin
                            n_idx       = idx_inc;
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = idx_inc[AW-1:0];
                        end else begin
                            n_count = n_wr;
                            n_state = S_IDLE;
                        end
                    end

                    OP_TICK: begin
                        if (is_due && r_pend_vld && !out_free) begin
                            // hold on this entry until the output frees up
                            n_state = S_SCAN;
                        end else begin
                            if (is_due) begin
                                push          = r_pend_vld;
                                n_pend_vld    = 1'b1;
                                n_pend_kind   = KIND_FIRED;
                                n_pend_script = mem_rd_entry.script;
                                n_pend_id     = mem_rd_entry.id;
                                if (mem_rd_entry.repeats) begin
                                    add_b                 = mem_rd_entry.duration;
                                    mem_wr_entry.deadline = add_sum;
                                    mem_wr_en             = 1'b1;
                                    n_wr                  = r_wr + CW'(1);
                                end
                            end else begin
                                mem_wr_en = 1'b1;
                                n_wr      = r_wr + CW'(1);
                            end
                            if (more) begin
                                n_idx       = idx_inc;
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = idx_inc[AW-1:0];
                            end else begin
                                n_count = n_wr;
                                n_state = S_FLUSH;
                            end
                        end
                    end

                    OP_RESUME, OP_ENG_RESUME: begin
                        add_a                 = mem_rd_entry.deadline;
                        add_b                 = r_span;
                        mem_wr_entry.deadline = add_sum;
                        mem_wr_en             = 1'b1;
                        mem_wr_addr           = r_idx[AW-1:0];
                        if (more) begin
                            n_idx       = idx_inc;
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = idx_inc[AW-1:0];
                        end else begin
                            n_state = S_IDLE;
                        end
                    end

                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_APPEND: begin
                if (r_count == FULL_COUNT) begin
                    n_pend_vld    = 1'b1;
                    n_pend_kind   = KIND_REFUSED;
                    n_pend_script = '0;
                    n_pend_id     = r_id;
                    n_state       = S_FLUSH;
                end else begin
                    mem_wr_en             = 1'b1;
                    mem_wr_addr           = r_count[AW-1:0];
                    mem_wr_entry.id       = r_id;
                    mem_wr_entry.script   = r_script;
                    mem_wr_entry.duration = r_dur;
                    mem_wr_entry.repeats  = r_rep;
                    mem_wr_entry.deadline = add_sum;
                    n_count               = r_count + CW'(1);
                    n_state               = S_IDLE;
                end
            end

            S_FLUSH: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register: drop on take, load from the holding register on push
    always_comb begin
        n_out_vld    = r_out_vld && !i_m_axis_tready;
        n_out_kind   = r_out_kind;
        n_out_script = r_out_script;
        n_out_id     = r_out_id;
        n_out_last   = r_out_last;
        if (push) begin
            n_out_vld    = 1'b1;
            n_out_kind   = r_pend_kind;
            n_out_script = r_pend_script;
            n_out_id     = r_pend_id;
            n_out_last   = push_last;
        end
    end

endmodule

@@ hw/rtl/tts_table.sv @@
// Timer table storage: one write port and one registered read port.
// Depends on tts_pkg for the entry type.
module tts_table
    import tts_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_entry,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_entry
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

@@ hw/rtl/tts_checker.sv @@
// Port-level checks for the timer table scheduler, bound to the top level.
// No package dependency; sees the top-level ports only.
module tts_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [63:0]  o_m_axis_tdata,
    input logic [0:0]   o_m_axis_tuser,
    input logic         o_m_axis_tlast
);

    // an accepted command always makes the sequencer busy, so ready drops after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
    else $error("command accepted while the previous one was still starting");

    // a refusal is the only result of its set and carries no script
    a_refusal_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tlast && (o_m_axis_tdata[31:0] == 32'd0))
    else $error("refusal result without tlast or with a script");

    // a new result only appears while a command is in work
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
    else $error("result appeared while the sequencer was idle");

    // a stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
    else $error("stalled result changed or dropped");

endmodule

bind timer_table_scheduler tts_checker u_tts_checker (.*);
